>>> rtl/core/beat_interval_tracker_macros.svh
// Assertion macros shared by the beat interval tracker RTL.
`ifndef BEAT_INTERVAL_TRACKER_MACROS_SVH
`define BEAT_INTERVAL_TRACKER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define BITRK_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define BITRK_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bitrk_pkg.sv
// Shared constants and types of the beat interval tracker.
`default_nettype none

package bitrk_pkg;

    // Default parameter values.
    localparam int DEF_FRACTION_BITS = 12;
    localparam int DEF_INTERVAL_BITS = 20;

    // Fixed field widths.
    localparam int NOTE_INT_BITS = 4;
    localparam int TOTAL_W       = 32;
    localparam int COUNT_W       = 16;
    localparam int PCT_W         = 7;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    // Register reset values and the percent scale.
    localparam int RESET_INTERVAL = 22050;
    localparam int RESET_PERCENT  = 4;
    localparam int PERCENT_SCALE  = 100;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NOTE_VALUE        = 2'd0,
        REG_TESTED_NOTE       = 2'd1,
        REG_INITIAL_INTERVAL  = 2'd2,
        REG_TOLERANCE_PERCENT = 2'd3
    } cfg_reg_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TOL_A,
        ST_TOL_B,
        ST_CHECK,
        ST_ROOT_MUL,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_EXP_MUL,
        ST_EXP_GO,
        ST_EXP_WAIT,
        ST_RELOAD,
        ST_DONE
    } seq_state_t;

endpackage

`default_nettype wire

>>> rtl/core/bitrk_cfg.sv
// Configuration registers of the beat interval tracker.
`default_nettype none

module bitrk_cfg #(
    parameter int FRACTION_BITS = bitrk_pkg::DEF_FRACTION_BITS,
    parameter int INTERVAL_BITS = bitrk_pkg::DEF_INTERVAL_BITS
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          wr_en,
    input  logic [bitrk_pkg::CFG_IDX_W-1:0]               wr_index,
    input  logic [bitrk_pkg::CFG_DATA_W-1:0]              wr_data,
    output logic [bitrk_pkg::NOTE_INT_BITS+FRACTION_BITS-1:0] note_value,
    output logic [bitrk_pkg::NOTE_INT_BITS+FRACTION_BITS-1:0] tested_note,
    output logic [INTERVAL_BITS-1:0]                      initial_interval,
    output logic [bitrk_pkg::PCT_W-1:0]                   tolerance_percent,
    output logic                                          reload
);

    localparam int NOTE_W = bitrk_pkg::NOTE_INT_BITS + FRACTION_BITS;

    localparam logic [NOTE_W-1:0]          RESET_NOTE = NOTE_W'(1) << FRACTION_BITS;
    localparam logic [INTERVAL_BITS-1:0]   RESET_IV   =
        INTERVAL_BITS'(bitrk_pkg::RESET_INTERVAL);
    localparam logic [bitrk_pkg::PCT_W-1:0] RESET_PCT  =
        bitrk_pkg::PCT_W'(bitrk_pkg::RESET_PERCENT);

    logic [NOTE_W-1:0]              note_value_reg,  note_value_next;
    logic [NOTE_W-1:0]              tested_note_reg, tested_note_next;
    logic [INTERVAL_BITS-1:0]       initial_reg,     initial_next;
    logic [bitrk_pkg::PCT_W-1:0]    percent_reg,     percent_next;
    bitrk_pkg::cfg_reg_t            index;

    assign index = bitrk_pkg::cfg_reg_t'(wr_index);

    // Decode a write request into the addressed register.
    always_comb
    begin
        note_value_next  = note_value_reg;
        tested_note_next = tested_note_reg;
        initial_next     = initial_reg;
        percent_next     = percent_reg;
        if (wr_en)
        begin
            unique case (index)
                bitrk_pkg::REG_NOTE_VALUE:        note_value_next  = wr_data[NOTE_W-1:0];
                bitrk_pkg::REG_TESTED_NOTE:       tested_note_next = wr_data[NOTE_W-1:0];
                bitrk_pkg::REG_INITIAL_INTERVAL:  initial_next     = wr_data[INTERVAL_BITS-1:0];
                bitrk_pkg::REG_TOLERANCE_PERCENT: percent_next     =
                    wr_data[bitrk_pkg::PCT_W-1:0];
                default:                          percent_next     = percent_reg;
            endcase
        end
    end

    // Any write except the percent one restarts the tracking state.
    assign reload = wr_en && (index != bitrk_pkg::REG_TOLERANCE_PERCENT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_value_reg  <= RESET_NOTE;
            tested_note_reg <= RESET_NOTE;
            initial_reg     <= RESET_IV;
            percent_reg     <= RESET_PCT;
        end
        else
        begin
            note_value_reg  <= note_value_next;
            tested_note_reg <= tested_note_next;
            initial_reg     <= initial_next;
            percent_reg     <= percent_next;
        end
    end

    assign note_value        = note_value_reg;
    assign tested_note       = tested_note_reg;
    assign initial_interval  = initial_reg;
    assign tolerance_percent = percent_reg;

endmodule

`default_nettype wire

>>> rtl/core/bitrk_div.sv
// Shared restoring divider with a saturated quotient, one bit per cycle.
`default_nettype none

`include "beat_interval_tracker_macros.svh"

module bitrk_div #(
    parameter int DVD_W = 48,
    parameter int DVS_W = 32,
    parameter int Q_W   = 20
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [Q_W-1:0]   quotient
);

    localparam int UP_W  = DVD_W - Q_W;
    localparam int CMP_W = (UP_W > DVS_W) ? UP_W : DVS_W;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic             busy_reg,  busy_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg,  done_next;
    logic [DVS_W-1:0] rem_reg,   rem_next;
    logic [Q_W-1:0]   quot_reg,  quot_next;
    logic [DVS_W-1:0] dvs_reg,   dvs_next;

    logic [UP_W-1:0]  upper;
    logic             saturate;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_diff;
    logic             take;

    // The quotient overflows Q_W bits exactly when the upper part reaches the divisor.
    // A zero divisor always lands here and gives all ones.
    assign upper    = dividend[DVD_W-1:Q_W];
    assign saturate = CMP_W'(upper) >= CMP_W'(divisor);

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign rem_sh   = {rem_reg, quot_reg[Q_W-1]};
    assign take     = rem_sh >= {1'b0, dvs_reg};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        dvs_next   = dvs_reg;
        if (start)
        begin
            dvs_next = divisor;
            if (saturate)
            begin
                quot_next = '1;
                done_next = 1'b1;
            end
            else
            begin
                rem_next   = DVS_W'(upper);
                quot_next  = dividend[Q_W-1:0];
                busy_next  = 1'b1;
                count_next = CNT_W'(Q_W);
            end
        end
        else if (busy_reg)
        begin
            rem_next   = take ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            quot_next  = {quot_reg[Q_W-2:0], take};
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

    `BITRK_ASSERT_IMP(a_start_when_idle, start, !busy_reg, "divider started while busy")
    `BITRK_ASSERT_IMP(a_done_not_busy, done_reg, !busy_reg, "divider done while still busy")

endmodule

`default_nettype wire

>>> rtl/core/beat_interval_tracker.sv
// Top level of the beat interval tracker: sequencer, tracking state and result register.
//
// Usage:
// - Input channel (in_valid/in_ready/tested_interval) takes one onset interval per
//   request; output channel (out_valid/out_ready) returns one result per request:
//   matched, confidence_count, root_estimate and expected_next.
// - Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes registers
//   0 note_value, 1 tested_note, 2 initial_interval, 3 tolerance_percent. Writing
//   registers 0 to 2 reloads the tracking state; neither channel is ready until the
//   reload has finished.
// - A missed interval goes through TOL_A, TOL_B and CHECK to DONE, where its result is
//   loaded. A matched interval runs two divisions through the shared divider, for the
//   root estimate and the expected interval; a saturating quotient skips its loop.
// - One request is processed at a time, so a new request is taken once the previous
//   result has reached the output register.
// - The output register frees the input side: the next request is accepted while a
//   result waits. If the receiver stalls, the following result holds in the sequencer
//   until the output register is taken.
// - Reset restores the register defaults and the tracking state derived from them,
//   with no result pending.
`default_nettype none

`include "beat_interval_tracker_macros.svh"

module beat_interval_tracker #(
    parameter int FRACTION_BITS = bitrk_pkg::DEF_FRACTION_BITS,
    parameter int INTERVAL_BITS = bitrk_pkg::DEF_INTERVAL_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bitrk_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bitrk_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [INTERVAL_BITS-1:0]            tested_interval,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                matched,
    output logic [bitrk_pkg::COUNT_W-1:0]       confidence_count,
    output logic [INTERVAL_BITS-1:0]            root_estimate,
    output logic [INTERVAL_BITS-1:0]            expected_next
);

    localparam int NOTE_W  = bitrk_pkg::NOTE_INT_BITS + FRACTION_BITS;
    localparam int TOTAL_W = bitrk_pkg::TOTAL_W;
    localparam int COUNT_W = bitrk_pkg::COUNT_W;
    localparam int PCT_W   = bitrk_pkg::PCT_W;
    localparam int PROD_W  = TOTAL_W + NOTE_W;
    localparam int TOLP_W  = INTERVAL_BITS + NOTE_W + PCT_W;
    localparam int DEV_W   = INTERVAL_BITS + PCT_W;

    localparam logic [INTERVAL_BITS-1:0] RESET_IV   =
        INTERVAL_BITS'(bitrk_pkg::RESET_INTERVAL);
    localparam logic [NOTE_W-1:0]        RESET_NOTE = NOTE_W'(1) << FRACTION_BITS;

    // Configuration registers.
    logic [NOTE_W-1:0]        note_value;
    logic [NOTE_W-1:0]        tested_note;
    logic [INTERVAL_BITS-1:0] initial_interval;
    logic [PCT_W-1:0]         tolerance_percent;
    logic                     cfg_reload;
    logic                     cfg_wr;
    logic                     in_acc;

    // Sequencer and tracking state.
    bitrk_pkg::seq_state_t    state_reg, state_next;
    logic                     reload_reg, reload_next;
    logic [INTERVAL_BITS-1:0] root_reg, root_next;
    logic [TOTAL_W-1:0]       sample_total_reg, sample_total_next;
    logic [TOTAL_W-1:0]       beat_total_reg, beat_total_next;
    logic [COUNT_W-1:0]       match_count_reg, match_count_next;
    logic [INTERVAL_BITS-1:0] expected_reg, expected_next_val;

    // Working registers.
    logic [INTERVAL_BITS-1:0] iv_reg, iv_next;
    logic [INTERVAL_BITS-1:0] diff_reg, diff_next;
    logic [DEV_W-1:0]         dev_reg, dev_next;
    logic [PROD_W-1:0]        mul_reg, mul_next;
    logic [TOLP_W-1:0]        tolp_reg, tolp_next;
    logic                     hit_reg, hit_next;

    // Result register.
    logic                     out_valid_reg, out_valid_next;
    logic                     matched_reg, matched_next;
    logic [COUNT_W-1:0]       conf_out_reg, conf_out_next;
    logic [INTERVAL_BITS-1:0] root_out_reg, root_out_next;
    logic [INTERVAL_BITS-1:0] exp_out_reg, exp_out_next;

    // Shared multiplier and divider.
    logic [TOTAL_W-1:0]       mul_a;
    logic [NOTE_W-1:0]        mul_b;
    logic [PROD_W-1:0]        mul_prod;
    logic                     div_start;
    logic [TOTAL_W-1:0]       div_divisor;
    logic                     div_done;
    logic [INTERVAL_BITS-1:0] div_quot;

    logic                     hit_now;
    logic                     out_free;
    logic                     out_load;
    logic [TOTAL_W:0]         sample_sum;
    logic [TOTAL_W:0]         beat_sum;

    bitrk_cfg #(
        .FRACTION_BITS (FRACTION_BITS),
        .INTERVAL_BITS (INTERVAL_BITS)
    ) u_cfg (
        .clk               (clk),
        .rst_n             (rst_n),
        .wr_en             (cfg_wr),
        .wr_index          (cfg_index),
        .wr_data           (cfg_data),
        .note_value        (note_value),
        .tested_note       (tested_note),
        .initial_interval  (initial_interval),
        .tolerance_percent (tolerance_percent),
        .reload            (cfg_reload)
    );

    bitrk_div #(
        .DVD_W (PROD_W),
        .DVS_W (TOTAL_W),
        .Q_W   (INTERVAL_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_reg),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign cfg_wr   = cfg_valid && cfg_ready;
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // The interval matches when diff * 100 * 2^FRACTION_BITS does not exceed
    // root * note_value * percent, which equals the truncated tolerance test.
    assign hit_now = TOLP_W'({dev_reg, {FRACTION_BITS{1'b0}}}) <= tolp_reg;

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = (state_reg == bitrk_pkg::ST_ROOT_MUL) ? sample_total_reg : TOTAL_W'(root_reg);
        mul_b = (state_reg == bitrk_pkg::ST_EXP_MUL) ? tested_note : note_value;
    end
    assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Saturating total updates.
    assign sample_sum = {1'b0, sample_total_reg} + (TOTAL_W + 1)'(iv_reg);
    assign beat_sum   = {1'b0, beat_total_reg} + (TOTAL_W + 1)'(tested_note);

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bitrk_pkg::ST_IDLE:
            begin
                if (cfg_wr && cfg_reload)
                begin
                    state_next = bitrk_pkg::ST_RELOAD;
                end
                else if (in_acc)
                begin
                    state_next = bitrk_pkg::ST_TOL_A;
                end
            end
            bitrk_pkg::ST_TOL_A:     state_next = bitrk_pkg::ST_TOL_B;
            bitrk_pkg::ST_TOL_B:     state_next = bitrk_pkg::ST_CHECK;
            bitrk_pkg::ST_CHECK:
                state_next = hit_now ? bitrk_pkg::ST_ROOT_MUL : bitrk_pkg::ST_DONE;
            bitrk_pkg::ST_ROOT_MUL:  state_next = bitrk_pkg::ST_ROOT_GO;
            bitrk_pkg::ST_ROOT_GO:   state_next = bitrk_pkg::ST_ROOT_WAIT;
            bitrk_pkg::ST_ROOT_WAIT:
            begin
                if (div_done)
                begin
                    state_next = bitrk_pkg::ST_EXP_MUL;
                end
            end
            bitrk_pkg::ST_EXP_MUL:   state_next = bitrk_pkg::ST_EXP_GO;
            bitrk_pkg::ST_EXP_GO:    state_next = bitrk_pkg::ST_EXP_WAIT;
            bitrk_pkg::ST_EXP_WAIT:
            begin
                if (div_done)
                begin
                    state_next = reload_reg ? bitrk_pkg::ST_IDLE : bitrk_pkg::ST_DONE;
                end
            end
            bitrk_pkg::ST_RELOAD:    state_next = bitrk_pkg::ST_EXP_MUL;
            bitrk_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = bitrk_pkg::ST_IDLE;
                end
            end
            default:                 state_next = bitrk_pkg::ST_IDLE;
        endcase
    end

    // Output decode of the sequencer.
    always_comb
    begin
        cfg_ready   = 1'b0;
        in_ready    = 1'b0;
        div_start   = 1'b0;
        div_divisor = beat_total_reg;
        out_load    = 1'b0;
        unique case (state_reg)
            bitrk_pkg::ST_IDLE:
            begin
                cfg_ready = 1'b1;
                in_ready  = !cfg_valid;
            end
            bitrk_pkg::ST_ROOT_GO:
            begin
                div_start = 1'b1;
            end
            bitrk_pkg::ST_EXP_GO:
            begin
                div_start   = 1'b1;
                div_divisor = TOTAL_W'(note_value);
            end
            bitrk_pkg::ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Datapath next values, driven by the sequencer state.
    always_comb
    begin
        reload_next       = reload_reg;
        root_next         = root_reg;
        sample_total_next = sample_total_reg;
        beat_total_next   = beat_total_reg;
        match_count_next  = match_count_reg;
        expected_next_val = expected_reg;
        iv_next           = iv_reg;
        diff_next         = diff_reg;
        dev_next          = dev_reg;
        mul_next          = mul_reg;
        tolp_next         = tolp_reg;
        hit_next          = hit_reg;

        // Capture a request, or note that a reload has been requested.
        if (cfg_wr && cfg_reload)
        begin
            reload_next = 1'b1;
        end
        else if (in_acc)
        begin
            reload_next = 1'b0;
            iv_next     = tested_interval;
        end

        unique case (state_reg)
            bitrk_pkg::ST_TOL_A:
            begin
                mul_next  = mul_prod;
                diff_next = (expected_reg >= iv_reg) ? (expected_reg - iv_reg)
                                                     : (iv_reg - expected_reg);
            end
            bitrk_pkg::ST_TOL_B:
            begin
                tolp_next = TOLP_W'(mul_reg[INTERVAL_BITS+NOTE_W-1:0]) * TOLP_W'(tolerance_percent);
                dev_next  = DEV_W'(diff_reg) * DEV_W'(bitrk_pkg::PERCENT_SCALE);
            end
            bitrk_pkg::ST_CHECK:
            begin
                hit_next = hit_now;
                if (hit_now)
                begin
                    if (match_count_reg != '1)
                    begin
                        match_count_next = match_count_reg + COUNT_W'(1);
                    end
                    sample_total_next = sample_sum[TOTAL_W] ? '1 : sample_sum[TOTAL_W-1:0];
                    beat_total_next   = beat_sum[TOTAL_W] ? '1 : beat_sum[TOTAL_W-1:0];
                end
            end
            bitrk_pkg::ST_ROOT_MUL,
            bitrk_pkg::ST_EXP_MUL:
            begin
                mul_next = mul_prod;
            end
            bitrk_pkg::ST_ROOT_WAIT:
            begin
                if (div_done)
                begin
                    root_next = div_quot;
                end
            end
            bitrk_pkg::ST_EXP_WAIT:
            begin
                if (div_done)
                begin
                    expected_next_val = div_quot;
                end
            end
            bitrk_pkg::ST_RELOAD:
            begin
                root_next         = initial_interval;
                sample_total_next = TOTAL_W'(initial_interval);
                beat_total_next   = TOTAL_W'(note_value);
                match_count_next  = '0;
            end
            default:
            begin
                mul_next = mul_reg;
            end
        endcase
    end

    // Result register: loaded from the sequencer, cleared when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        matched_next   = matched_reg;
        conf_out_next  = conf_out_reg;
        root_out_next  = root_out_reg;
        exp_out_next   = exp_out_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            matched_next   = hit_reg;
            conf_out_next  = match_count_reg;
            root_out_next  = root_reg;
            exp_out_next   = expected_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and tracking state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bitrk_pkg::ST_IDLE;
            reload_reg       <= 1'b0;
            root_reg         <= RESET_IV;
            sample_total_reg <= TOTAL_W'(RESET_IV);
            beat_total_reg   <= TOTAL_W'(RESET_NOTE);
            match_count_reg  <= '0;
            expected_reg     <= RESET_IV;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            reload_reg       <= reload_next;
            root_reg         <= root_next;
            sample_total_reg <= sample_total_next;
            beat_total_reg   <= beat_total_next;
            match_count_reg  <= match_count_next;
            expected_reg     <= expected_next_val;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        iv_reg       <= iv_next;
        diff_reg     <= diff_next;
        dev_reg      <= dev_next;
        mul_reg      <= mul_next;
        tolp_reg     <= tolp_next;
        hit_reg      <= hit_next;
        matched_reg  <= matched_next;
        conf_out_reg <= conf_out_next;
        root_out_reg <= root_out_next;
        exp_out_reg  <= exp_out_next;
    end

    assign out_valid        = out_valid_reg;
    assign matched          = matched_reg;
    assign confidence_count = conf_out_reg;
    assign root_estimate    = root_out_reg;
    assign expected_next    = exp_out_reg;

    `BITRK_ASSERT_NXT(a_accept_starts_check, in_valid && in_ready, state_reg == bitrk_pkg::ST_TOL_A, "accepted request did not start the tolerance check")
    `BITRK_ASSERT_IMP(a_div_done_in_wait, div_done, state_reg == bitrk_pkg::ST_ROOT_WAIT || state_reg == bitrk_pkg::ST_EXP_WAIT, "divider finished outside a wait state")
    `BITRK_ASSERT_NXT(a_miss_keeps_state, state_reg == bitrk_pkg::ST_CHECK && !hit_now, $stable(match_count_reg) && $stable(root_reg), "missed interval changed the tracking state")

endmodule

`default_nettype wire
